FILE: src/assert_macros.svh
// Concurrent assertion helpers, compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("%m: assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: src/mf3_pkg.sv
package mf3_pkg;

   localparam int MAX_WIDTH_DEFAULT = 2048;
   localparam int PIXEL_W = 8;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W = 12;
   localparam int ROW_W = 12;
   localparam int MIN_DIM = 3;
   localparam int FIRST_INTERIOR = 2;
   localparam int WIN_TAPS = 9;
   localparam int WIN_HIST = 6;
   localparam int MEDIAN_TAP = 4;
   localparam int WQ_DEPTH = 4;
   localparam int OUT_DEPTH = 4;

   localparam logic [CSR_DATA_W-1:0] WIDTH_RESET = CSR_DATA_W'(640);
   localparam logic [CSR_DATA_W-1:0] HEIGHT_RESET = CSR_DATA_W'(480);

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   localparam csr_index_type CSR_IMAGE_WIDTH = csr_index_type'(0);
   localparam csr_index_type CSR_IMAGE_HEIGHT = csr_index_type'(1);

   typedef logic [PIXEL_W-1:0] pixel_type;
   typedef pixel_type [WIN_TAPS-1:0] window_type;

   typedef struct packed {
      logic last;
      window_type taps;
   } win_beat_type;

   typedef struct packed {
      pixel_type median_value;
      logic last;
   } rsp_beat_type;

   // 19-op compare-exchange network; after all ops, tap 4 holds the median
   localparam int NET_OPS = 19;
   localparam int NET_LO [NET_OPS] = '{1, 4, 7, 0, 3, 6, 1, 4, 7, 0, 5, 4, 3, 1, 2, 4, 4, 6, 4};
   localparam int NET_HI [NET_OPS] = '{2, 5, 8, 1, 4, 7, 2, 5, 8, 3, 8, 7, 6, 4, 5, 7, 2, 4, 2};
   localparam int STAGE_A_END = 8;
   localparam int STAGE_B_END = 15;

   function automatic window_type net_apply(window_type w, int first_op, int last_op);
      window_type r;
      pixel_type t;
      r = w;
      for (int i = 0; i < NET_OPS; i++) begin
         if (i >= first_op && i <= last_op) begin
            if (r[NET_LO[i]] > r[NET_HI[i]]) begin
               t = r[NET_LO[i]];
               r[NET_LO[i]] = r[NET_HI[i]];
               r[NET_HI[i]] = t;
            end
         end
      end
      return r;
   endfunction

endpackage

FILE: src/mf3_fifo.sv
module mf3_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   input  logic [WIDTH-1:0]             push_data,
   input  logic                         pop,
   output logic [WIDTH-1:0]             pop_data,
   output logic                         empty,
   output logic [$clog2(DEPTH+1)-1:0]   count
);
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data = mem[rd_ptr_ff];
   assign empty = (count_ff == '0);
   assign count = count_ff;

endmodule

FILE: src/mf3_front.sv
module mf3_front #(
   parameter int MAX_WIDTH = mf3_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [mf3_pkg::CSR_DATA_W-1:0]       image_width,
   input  logic [mf3_pkg::CSR_DATA_W-1:0]       image_height,
   input  logic                                 accept,
   input  mf3_pkg::pixel_type                   pixel,
   output logic                                 wq_push,
   output mf3_pkg::win_beat_type                wq_data,
   output logic                                 busy
);
   import mf3_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int LIM_W = ($clog2(MAX_WIDTH + 1) > CSR_DATA_W) ?
                          $clog2(MAX_WIDTH + 1) : CSR_DATA_W;

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [LIM_W-1:0] width_ext, width_eff, col_last;
   logic [ROW_W-1:0] height_eff, row_last;
   logic row_end, frame_end, interior;

   logic s1_valid_ff;
   logic s1_interior_ff;
   logic s1_last_ff;
   logic [COL_W-1:0] s1_col_ff;
   pixel_type s1_pixel_ff;
   pixel_type above_rd_ff;
   pixel_type two_rd_ff;
   pixel_type hist_ff [WIN_HIST];

   pixel_type above_mem [MAX_WIDTH];
   pixel_type two_mem [MAX_WIDTH];

   always_comb begin
      width_ext = LIM_W'(image_width);
      if (width_ext < LIM_W'(MIN_DIM)) begin
         width_eff = LIM_W'(MIN_DIM);
      end else if (width_ext > LIM_W'(MAX_WIDTH)) begin
         width_eff = LIM_W'(MAX_WIDTH);
      end else begin
         width_eff = width_ext;
      end
      col_last = width_eff - 1'b1;
      height_eff = (image_height < ROW_W'(MIN_DIM)) ? ROW_W'(MIN_DIM) : image_height;
      row_last = height_eff - 1'b1;
      row_end = (LIM_W'(col_ff) >= col_last);
      frame_end = row_end && (row_ff >= row_last);
      interior = (col_ff >= COL_W'(FIRST_INTERIOR)) && (row_ff >= ROW_W'(FIRST_INTERIOR));
      col_in = col_ff + 1'b1;
      row_in = row_ff;
      if (row_end) begin
         col_in = '0;
         row_in = frame_end ? '0 : row_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_interior_ff <= interior;
         s1_last_ff <= frame_end;
         s1_col_ff <= col_ff;
         s1_pixel_ff <= pixel;
      end
   end

   // line stores: read at accept, written back from the stage-1 registers (s1_col_ff, s1_pixel_ff, above_rd_ff)
   always_ff @(posedge clock) begin
      if (accept) begin
         above_rd_ff <= above_mem[col_ff];
         two_rd_ff <= two_mem[col_ff];
      end
      if (s1_valid_ff) begin
         above_mem[s1_col_ff] <= s1_pixel_ff;
         two_mem[s1_col_ff] <= above_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WIN_HIST; i++) begin
            hist_ff[i] <= '0;
         end
      end else if (s1_valid_ff) begin
         hist_ff[0] <= hist_ff[3];
         hist_ff[1] <= hist_ff[4];
         hist_ff[2] <= hist_ff[5];
         hist_ff[3] <= two_rd_ff;
         hist_ff[4] <= above_rd_ff;
         hist_ff[5] <= s1_pixel_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < WIN_HIST; i++) begin
         wq_data.taps[i] = hist_ff[i];
      end
      wq_data.taps[WIN_HIST] = two_rd_ff;
      wq_data.taps[WIN_HIST+1] = above_rd_ff;
      wq_data.taps[WIN_HIST+2] = s1_pixel_ff;
      wq_data.last = s1_last_ff;
   end

   assign wq_push = s1_valid_ff && s1_interior_ff;
   assign busy = s1_valid_ff;

endmodule

FILE: src/mf3_back.sv
module mf3_back #(
   parameter int OUT_DEPTH = mf3_pkg::OUT_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               wq_empty,
   input  mf3_pkg::win_beat_type              wq_data,
   output logic                               wq_pop,
   input  logic [$clog2(OUT_DEPTH+1)-1:0]     out_count,
   output logic                               out_push,
   output mf3_pkg::rsp_beat_type              out_data,
   output logic [1:0]                         inflight
);
   import mf3_pkg::*;

   localparam int CNT_W = $clog2(OUT_DEPTH + 1);

   logic a_valid_ff, b_valid_ff;
   logic a_last_ff, b_last_ff;
   window_type a_win_ff, b_win_ff;
   window_type final_win;
   logic [CNT_W:0] used;

   // credit: results in the network always have a slot in the output queue
   assign inflight = {1'b0, a_valid_ff} + {1'b0, b_valid_ff};
   assign used = (CNT_W + 1)'(out_count) + (CNT_W + 1)'(inflight);
   assign wq_pop = !wq_empty && (used < (CNT_W + 1)'(OUT_DEPTH));

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= wq_pop;
         b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wq_pop) begin
         a_win_ff <= net_apply(wq_data.taps, 0, STAGE_A_END);
         a_last_ff <= wq_data.last;
      end
      if (a_valid_ff) begin
         b_win_ff <= net_apply(a_win_ff, STAGE_A_END + 1, STAGE_B_END);
         b_last_ff <= a_last_ff;
      end
   end

   assign final_win = net_apply(b_win_ff, STAGE_B_END + 1, NET_OPS - 1);
   assign out_push = b_valid_ff;
   assign out_data.median_value = final_win[MEDIAN_TAP];
   assign out_data.last = b_last_ff;

endmodule

FILE: src/median_3x3_pixel_filter.sv
// 3x3 median filter over a raster-order stream of 8-bit grey pixels.
// Input queue side: drive req_pixel and req_push; a beat is taken on a clock
// edge where req_push is high and req_full is low. One pixel per cycle is
// sustained while the result side keeps up.
// Result queue side: while rsp_empty is low, rsp_median_value and rsp_last
// show the oldest result; rsp_pop takes it. Only interior positions (row >= 2,
// column >= 2) give a result; rsp_last marks the final one of a frame.
// Path from the accepting edge to rsp_empty going low: the line store read, the
// window queue, the two-stage sorting network and the output queue, all registered.
// Throughput: 1 pixel per cycle while the result side keeps up; req_full stalls it otherwise.
// Configuration: csr_index 0 = image width, 1 = image height; csr_ready is
// always high. Write only while the block is idle.
// Reset (synchronous) empties both queues, clears position counters and
// sets width 640, height 480; line stores are not cleared.
// When the receiver stalls, results collect in a 4-entry output queue, then
// a 4-entry window queue, after which req_full rises; nothing is dropped.
`include "assert_macros.svh"

module median_3x3_pixel_filter #(
   parameter int MAX_WIDTH = mf3_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_push,
   output logic                              req_full,
   input  logic [mf3_pkg::PIXEL_W-1:0]       req_pixel,
   output logic                              rsp_empty,
   input  logic                              rsp_pop,
   output logic [mf3_pkg::PIXEL_W-1:0]       rsp_median_value,
   output logic                              rsp_last,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  mf3_pkg::csr_index_type            csr_index,
   input  logic [mf3_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import mf3_pkg::*;

   localparam int WQ_CNT_W = $clog2(WQ_DEPTH + 1);
   localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);
   localparam int WB_W = $bits(win_beat_type);
   localparam int RB_W = $bits(rsp_beat_type);

   logic [CSR_DATA_W-1:0] width_ff, height_ff;
   logic req_accept;
   logic front_busy;
   logic wq_push, wq_pop, wq_empty;
   logic [WQ_CNT_W-1:0] wq_count;
   logic [WQ_CNT_W:0] wq_used;
   win_beat_type wq_in_data, wq_out_data;
   logic out_push, out_pop;
   logic [OUT_CNT_W-1:0] out_count;
   rsp_beat_type out_in_data, out_head;
   logic [1:0] back_inflight;
   logic [OUT_CNT_W:0] out_used;
   logic wq_at_depth, out_at_depth;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH: width_ff <= csr_wdata;
            CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign wq_used = (WQ_CNT_W + 1)'(wq_count) + (WQ_CNT_W + 1)'(front_busy);
   assign req_full = (wq_used >= (WQ_CNT_W + 1)'(WQ_DEPTH));
   assign req_accept = req_push && !req_full;

   mf3_front #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_front (
      .clock(clock),
      .reset(reset),
      .image_width(width_ff),
      .image_height(height_ff),
      .accept(req_accept),
      .pixel(req_pixel),
      .wq_push(wq_push),
      .wq_data(wq_in_data),
      .busy(front_busy)
   );

   mf3_fifo #(
      .WIDTH(WB_W),
      .DEPTH(WQ_DEPTH)
   ) u_win_queue (
      .clock(clock),
      .reset(reset),
      .push(wq_push),
      .push_data(wq_in_data),
      .pop(wq_pop),
      .pop_data(wq_out_data),
      .empty(wq_empty),
      .count(wq_count)
   );

   mf3_back #(
      .OUT_DEPTH(OUT_DEPTH)
   ) u_back (
      .clock(clock),
      .reset(reset),
      .wq_empty(wq_empty),
      .wq_data(wq_out_data),
      .wq_pop(wq_pop),
      .out_count(out_count),
      .out_push(out_push),
      .out_data(out_in_data),
      .inflight(back_inflight)
   );

   assign out_pop = rsp_pop && !rsp_empty;

   mf3_fifo #(
      .WIDTH(RB_W),
      .DEPTH(OUT_DEPTH)
   ) u_rsp_queue (
      .clock(clock),
      .reset(reset),
      .push(out_push),
      .push_data(out_in_data),
      .pop(out_pop),
      .pop_data(out_head),
      .empty(rsp_empty),
      .count(out_count)
   );

   assign rsp_median_value = out_head.median_value;
   assign rsp_last = out_head.last;

   assign out_used = (OUT_CNT_W + 1)'(out_count) + (OUT_CNT_W + 1)'(back_inflight);
   assign wq_at_depth = (wq_count == WQ_CNT_W'(WQ_DEPTH));
   assign out_at_depth = (out_count == OUT_CNT_W'(OUT_DEPTH));

   `ASSERT_IMPLIES(a_wq_no_overflow, clock, reset, wq_push, !wq_at_depth || wq_pop)
   `ASSERT_IMPLIES(a_out_no_overflow, clock, reset, out_push, !out_at_depth || out_pop)
   `ASSERT_ALWAYS(a_out_credit, clock, reset, out_used <= (OUT_CNT_W + 1)'(OUT_DEPTH))
   `ASSERT_IMPLIES(a_window_follows_accept, clock, reset, wq_push, $past(req_accept))

endmodule
